FILE: hw/rtl/imu_median_outlier_check_defines.svh
// Assertion macros shared by the outlier check RTL.
// Needs signals named clk and rst_n in the scope that uses them.
`ifndef IMU_MEDIAN_OUTLIER_CHECK_DEFINES_SVH
`define IMU_MEDIAN_OUTLIER_CHECK_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IMC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("imc: implication check failed");

// Next-cycle implication, checked outside reset.
`define IMC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("imc: next-cycle check failed");

`endif

FILE: hw/rtl/imc_pkg.sv
// Package for the IMU median outlier check: widths, reset values, register
// codes and shared types. No dependencies.
package imc_pkg;

  localparam int unsigned NUM_CHAN       = 10;
  localparam int unsigned NUM_ACCEL      = 3;
  localparam int unsigned WINDOW_LEN_DEF = 9;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned LIMIT_W  = 31;
  localparam int unsigned DIFF_W   = SAMPLE_W + 1;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [LIMIT_W-1:0]  limit_t;
  typedef logic signed [DIFF_W-1:0]   diff_t;
  typedef logic        [NUM_CHAN-1:0] mask_t;

  localparam limit_t ACCEL_LIMIT_RST = limit_t'(262144);
  localparam limit_t OTHER_LIMIT_RST = limit_t'(65536);

  // Register index, taken from paddr[2].
  typedef enum logic [0:0] {
    REG_ACCEL_LIMIT = 1'b0,
    REG_OTHER_LIMIT = 1'b1
  } reg_idx_t;

  // Control of the difference stage between lanes and merge.
  typedef struct packed {
    logic valid;
    logic full;
  } stage_t;

endpackage

FILE: hw/rtl/imc_if.sv
// Valid/ready channel interfaces for sample sets and alarm results.
// Depends on imc_pkg.
interface imc_in_if
  import imc_pkg::*;
  ();
  logic    valid;
  logic    ready;
  sample_t accel_x;
  sample_t accel_y;
  sample_t accel_z;
  sample_t gyro_x;
  sample_t gyro_y;
  sample_t gyro_z;
  sample_t orient_x;
  sample_t orient_y;
  sample_t orient_z;
  sample_t orient_w;

  modport source (
    output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
           orient_x, orient_y, orient_z, orient_w,
    input  ready
  );
  modport sink (
    input  valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
           orient_x, orient_y, orient_z, orient_w,
    output ready
  );
endinterface

interface imc_out_if
  import imc_pkg::*;
  ();
  logic  valid;
  logic  ready;
  mask_t alarm_mask;
  logic  window_full;

  modport source (output valid, alarm_mask, window_full, input ready);
  modport sink (input valid, alarm_mask, window_full, output ready);
endinterface

FILE: hw/rtl/imc_cfg.sv
// APB-style register file holding the two outlier limits.
// Depends on imc_pkg.
module imc_cfg
  import imc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output limit_t                accel_limit,
  output limit_t                other_limit
);

  limit_t   accel_limit_r;
  limit_t   other_limit_r;
  reg_idx_t reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_limit_r <= ACCEL_LIMIT_RST;
      other_limit_r <= OTHER_LIMIT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ACCEL_LIMIT: accel_limit_r <= pwdata[LIMIT_W-1:0];
        REG_OTHER_LIMIT: other_limit_r <= pwdata[LIMIT_W-1:0];
        default:         accel_limit_r <= accel_limit_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ACCEL_LIMIT: prdata = {1'b0, accel_limit_r};
      REG_OTHER_LIMIT: prdata = {1'b0, other_limit_r};
      default:         prdata = '0;
    endcase
  end

  assign accel_limit = accel_limit_r;
  assign other_limit = other_limit_r;

endmodule

FILE: hw/rtl/imc_lane.sv
// One channel lane: sample window with running ranks, median pick and
// registered median-minus-sample difference. Depends on imc_pkg and the defines header.
`include "imu_median_outlier_check_defines.svh"

module imc_lane
  import imc_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = WINDOW_LEN_DEF,
  localparam int unsigned RW = $clog2(WINDOW_LEN),
  localparam int unsigned FW = $clog2(WINDOW_LEN + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic          full,
  input  logic [FW-1:0] fill_count,
  input  sample_t       sample,
  output diff_t         diff
);

  localparam int unsigned MID = WINDOW_LEN / 2;

  // Position 0 is the oldest entry, WINDOW_LEN-1 the newest.
  sample_t               win_r   [WINDOW_LEN];
  logic [RW-1:0]         rank_r  [WINDOW_LEN];
  logic [RW-1:0]         rank_nxt[WINDOW_LEN];
  diff_t                 diff_r;
  diff_t                 diff_nxt;
  sample_t               median;
  logic [WINDOW_LEN-1:0] pos_valid;
  logic [WINDOW_LEN-1:0] lt_new;
  logic [WINDOW_LEN-1:0] le_new;
  logic [WINDOW_LEN-1:0] drop_lt;
  logic [WINDOW_LEN-1:0] mid_hit;
  logic [WINDOW_LEN-1:0] min_hit;
  logic [WINDOW_LEN-1:0] max_hit;

  // Rank order: by value, ties broken by age (older ranks lower).
  always_comb begin
    median = '0;
    for (int j = 0; j < WINDOW_LEN; j++) begin
      pos_valid[j] = ((FW+1)'(j) + {1'b0, fill_count}) >= (FW+1)'(WINDOW_LEN);
      lt_new[j]    = sample < win_r[j];
      le_new[j]    = pos_valid[j] && !lt_new[j] && (j != 0);
      drop_lt[j]   = rank_r[0] < rank_r[j];
      mid_hit[j]   = rank_r[j] == RW'(MID);
      min_hit[j]   = rank_r[j] == '0;
      max_hit[j]   = rank_r[j] == RW'(WINDOW_LEN - 1);
      if (mid_hit[j]) begin
        median = median | win_r[j];
      end
    end
    for (int j = 1; j < WINDOW_LEN; j++) begin
      rank_nxt[j-1] = rank_r[j] - RW'(full && drop_lt[j]) + RW'(lt_new[j]);
    end
    rank_nxt[WINDOW_LEN-1] = RW'($countones(le_new));
    diff_nxt = {median[SAMPLE_W-1], median} - {sample[SAMPLE_W-1], sample};
  end

  // Advance the window on every transfer; the oldest entry drops out.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 1; j < WINDOW_LEN; j++) begin
        win_r[j-1] <= win_r[j];
      end
      win_r[WINDOW_LEN-1] <= sample;
      rank_r              <= rank_nxt;
      diff_r              <= diff_nxt;
    end
  end

  assign diff = diff_r;

  `IMC_ASSERT_IMP(a_mid_unique, full, $onehot(mid_hit))
  `IMC_ASSERT_IMP(a_min_unique, full, $onehot(min_hit))
  `IMC_ASSERT_IMP(a_max_unique, full, $onehot(max_hit))

endmodule

FILE: hw/rtl/imc_merge.sv
// Merge stage: folds lane differences against the limits into the alarm
// mask and holds the result register. Depends on imc_pkg and imc_out_if.
module imc_merge
  import imc_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  stage_t         stage,
  input  diff_t          diff [NUM_CHAN],
  input  limit_t         accel_limit,
  input  limit_t         other_limit,
  output logic           stage_take,
  imc_out_if.source      out_bus
);

  logic  out_valid_r;
  logic  out_valid_nxt;
  mask_t mask_r;
  mask_t mask_nxt;
  logic  full_r;
  diff_t mag;
  diff_t lim;

  always_comb begin
    mask_nxt = '0;
    for (int c = 0; c < NUM_CHAN; c++) begin
      mag = diff[c][DIFF_W-1] ? -diff[c] : diff[c];
      lim = (c < NUM_ACCEL) ? {2'b00, accel_limit} : {2'b00, other_limit};
      mask_nxt[c] = stage.full && (mag > lim);
    end
  end

  assign stage_take = stage.valid && (!out_valid_r || out_bus.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (stage_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_take) begin
      mask_r <= mask_nxt;
      full_r <= stage.full;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.alarm_mask  = mask_r;
  assign out_bus.window_full = full_r;

endmodule

FILE: hw/rtl/imu_median_outlier_check.sv
// Top level of the IMU sliding-median outlier check: ten channel lanes,
// merge stage and limit registers. Depends on imc_pkg, imc_if and submodules.
//
//   channel   ports               handshake          payload
//   input     in_bus (sink)       valid/ready        ten signed Q16.16 samples
//   result    out_bus (source)    valid/ready        alarm_mask, window_full
//   config    psel..prdata        APB write, 2 regs  accel_limit, other_limit
//
// One sample set is taken every cycle unless the result side stalls; after its
// transfer a result passes the difference stage, then the result register.
// Throughput is set by the rank update in each lane, which re-ranks a whole
// window in the transfer cycle so the next median is ready in the cycle after.
// Reset is synchronous: windows empty, limits at 4.0 and 1.0, no clearing pass.
// A stalled result holds the result register; the difference stage still
// takes one more set, after which in_bus.ready drops.
module imu_median_outlier_check
  import imc_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  imc_in_if.sink                in_bus,
  imc_out_if.source             out_bus,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

`include "imu_median_outlier_check_defines.svh"

  localparam int unsigned FW = $clog2(WINDOW_LEN + 1);

  logic [FW-1:0] fill_count_r;
  logic [FW-1:0] fill_count_nxt;
  logic          full;
  logic          in_accept;
  logic          stage_take;
  stage_t        stage_r;
  stage_t        stage_nxt;
  sample_t       samples [NUM_CHAN];
  diff_t         diffs   [NUM_CHAN];
  limit_t        accel_limit;
  limit_t        other_limit;

  // Limit registers.
  imc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .accel_limit (accel_limit),
    .other_limit (other_limit)
  );

  // Channel order matches the alarm mask bits.
  assign samples[0] = in_bus.accel_x;
  assign samples[1] = in_bus.accel_y;
  assign samples[2] = in_bus.accel_z;
  assign samples[3] = in_bus.gyro_x;
  assign samples[4] = in_bus.gyro_y;
  assign samples[5] = in_bus.gyro_z;
  assign samples[6] = in_bus.orient_x;
  assign samples[7] = in_bus.orient_y;
  assign samples[8] = in_bus.orient_z;
  assign samples[9] = in_bus.orient_w;

  // Take a new set whenever the difference stage is empty or drains this cycle.
  assign in_bus.ready = !stage_r.valid || stage_take;
  assign in_accept    = in_bus.valid && in_bus.ready;

  // Windows count as full once WINDOW_LEN sets went in; the count then holds.
  assign full = fill_count_r == FW'(WINDOW_LEN);

  always_comb begin
    fill_count_nxt = fill_count_r;
    if (in_accept && !full) begin
      fill_count_nxt = fill_count_r + 1'b1;
    end
  end

  // Difference stage control: advance on transfer, drop once merged.
  always_comb begin
    stage_nxt = stage_r;
    priority if (in_accept) begin
      stage_nxt.valid = 1'b1;
      stage_nxt.full  = full;
    end else if (stage_take) begin
      stage_nxt.valid = 1'b0;
    end else begin
      stage_nxt = stage_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_count_r <= '0;
      stage_r      <= '0;
    end else begin
      fill_count_r <= fill_count_nxt;
      stage_r      <= stage_nxt;
    end
  end

  // One lane per channel, all stepping on the same transfer.
  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
    imc_lane #(
      .WINDOW_LEN (WINDOW_LEN)
    ) u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .accept     (in_accept),
      .full       (full),
      .fill_count (fill_count_r),
      .sample     (samples[c]),
      .diff       (diffs[c])
    );
  end

  // Compare against the limits and hold the result.
  imc_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .stage       (stage_r),
    .diff        (diffs),
    .accel_limit (accel_limit),
    .other_limit (other_limit),
    .stage_take  (stage_take),
    .out_bus     (out_bus)
  );

  `IMC_ASSERT_IMP(a_fill_bound, 1'b1, fill_count_r <= FW'(WINDOW_LEN))
  `IMC_ASSERT_NXT(a_fill_step, in_accept && !full,
                  fill_count_r == FW'($past(fill_count_r) + 1'b1))
  `IMC_ASSERT_IMP(a_stall_blocks, stage_r.valid && !stage_take, !in_bus.ready)

endmodule

FILE: tb/testbench.sv
// Self-checking bench for imu_median_outlier_check: directed rows, then random sample sets.
// Windows, medians and limits are tracked in a local predictor; alarm results are compared.
// Depends on imc_pkg, imc_in_if/imc_out_if and the RTL top level.
module testbench;
  import imc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIN          = WINDOW_LEN_DEF;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned HOLD_OFF_LEN = 400;
  localparam int unsigned PHASE_ITEMS  = 340;
  localparam int unsigned NUM_PHASES   = 5;
  localparam int unsigned PRINT_CAP    = 100;
  localparam longint      S_MAX        = 64'sd2147483647;
  localparam longint      S_MIN        = -64'sd2147483648;
  localparam sample_t     Q_MAX        = 32'sh7FFF_FFFF;
  localparam sample_t     Q_MIN        = 32'sh8000_0000;

  typedef sample_t set_t [NUM_CHAN];

  typedef struct packed {
    mask_t mask;
    logic  full;
  } alarm_res_t;

  // One directed row: value for the accel group, value for the other channels, and a
  // per-channel step added as channel_index * step. Typed results only where chk is set.
  typedef struct packed {
    sample_t acc;
    sample_t oth;
    sample_t step;
    logic    chk;
    mask_t   mask;
    logic    full;
  } stim_row_t;

  // Rows 0-3 fill with the most negative code, 4-8 with the most positive, so the median
  // stays at the positive extreme for the first checked rows. Defaults: 4.0 and 1.0.
  localparam stim_row_t DIRECTED_ROWS [0:24] = '{
    '{Q_MIN,         Q_MIN,         32'sh0, 1'b1, 10'h000, 1'b0},
    '{Q_MIN,         Q_MIN,         32'sh0, 1'b1, 10'h000, 1'b0},
    '{Q_MIN,         Q_MIN,         32'sh0, 1'b1, 10'h000, 1'b0},
    '{Q_MIN,         Q_MIN,         32'sh0, 1'b1, 10'h000, 1'b0},
    '{Q_MAX,         Q_MAX,         32'sh0, 1'b1, 10'h000, 1'b0},
    '{Q_MAX,         Q_MAX,         32'sh0, 1'b1, 10'h000, 1'b0},
    '{Q_MAX,         Q_MAX,         32'sh0, 1'b1, 10'h000, 1'b0},
    '{Q_MAX,         Q_MAX,         32'sh0, 1'b1, 10'h000, 1'b0},
    '{Q_MAX,         Q_MAX,         32'sh0, 1'b1, 10'h000, 1'b0},
    // full span away from the median: every channel alarms
    '{Q_MIN,         Q_MIN,         32'sh0, 1'b1, 10'h3FF, 1'b1},
    // difference exactly at the limit: no alarm
    '{32'sh7FFB_FFFF, 32'sh7FFE_FFFF, 32'sh0, 1'b1, 10'h000, 1'b1},
    // one code past the limit: alarm
    '{32'sh7FFB_FFFE, 32'sh7FFE_FFFE, 32'sh0, 1'b1, 10'h3FF, 1'b1},
    '{Q_MAX,         Q_MAX,         32'sh0, 1'b1, 10'h000, 1'b1},
    '{32'sh0,        32'sh0,        32'sh0,         1'b0, 10'h000, 1'b0},
    '{-32'sh1,       -32'sh1,       32'sh0,         1'b0, 10'h000, 1'b0},
    '{32'sh1,        32'sh1,        32'sh1,         1'b0, 10'h000, 1'b0},
    '{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0101_0101, 1'b0, 10'h000, 1'b0},
    '{32'shAAAA_AAAA, 32'sh5555_5555, 32'sh1000_0001, 1'b0, 10'h000, 1'b0},
    '{32'sh0004_0000, 32'sh0001_0000, 32'sh0,         1'b0, 10'h000, 1'b0},
    '{32'shFFFC_0000, 32'shFFFF_0000, 32'sh0000_8000, 1'b0, 10'h000, 1'b0},
    '{32'sh0000_FFFF, 32'shFFFF_0001, 32'sh0000_0010, 1'b0, 10'h000, 1'b0},
    '{Q_MIN,         Q_MAX,         32'sh1,         1'b0, 10'h000, 1'b0},
    '{32'sh0001_E240, 32'shFFF6_030F, 32'sh0000_1000, 1'b0, 10'h000, 1'b0},
    '{32'sh0,        32'sh0,        32'sh0000_0100, 1'b0, 10'h000, 1'b0},
    '{Q_MAX,         Q_MIN,         32'sh0,         1'b0, 10'h000, 1'b0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  imc_in_if  in_bus ();
  imc_out_if out_bus ();

  imu_median_outlier_check i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // Predictor state: per-channel sample history (oldest first), fill level and limits.
  sample_t     win_hist [NUM_CHAN][WIN];
  int unsigned win_count = 0;
  limit_t      acc_lim_q = ACCEL_LIMIT_RST;
  limit_t      oth_lim_q = OTHER_LIMIT_RST;
  longint      drift_center [NUM_CHAN];

  alarm_res_t  pending_alarms [$];
  int unsigned err_cnt       = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned burst_left    = 0;
  bit          hold_off_req  = 1'b0;

  task automatic report_mismatch(input string msg);
    if (err_cnt < PRINT_CAP) $display("%0t mismatch: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic limit_t chan_limit(input int c);
    return (c < NUM_ACCEL) ? acc_lim_q : oth_lim_q;
  endfunction

  function automatic sample_t window_median(input int c);
    sample_t srt [WIN];
    sample_t key;
    int      j;
    for (int i = 0; i < WIN; i++) srt[i] = win_hist[c][i];
    for (int i = 1; i < WIN; i++) begin
      key = srt[i];
      j = i - 1;
      while (j >= 0 && srt[j] > key) begin
        srt[j + 1] = srt[j];
        j--;
      end
      srt[j + 1] = key;
    end
    return srt[WIN / 2];
  endfunction

  // Screen one sample set against the windows, then shift it in.
  function automatic alarm_res_t predict_alarms(input set_t s);
    alarm_res_t res;
    longint     d;
    bit         full;
    full = (win_count >= WIN);
    res.mask = '0;
    res.full = full;
    for (int c = 0; c < NUM_CHAN; c++) begin
      if (full) begin
        d = longint'(window_median(c)) - longint'(s[c]);
        if (d < 0) d = -d;
        if (d > longint'(chan_limit(c))) res.mask[c] = 1'b1;
        for (int k = 0; k < WIN - 1; k++) win_hist[c][k] = win_hist[c][k + 1];
        win_hist[c][WIN - 1] = s[c];
      end else begin
        win_hist[c][win_count] = s[c];
      end
    end
    if (!full) win_count++;
    return res;
  endfunction

  function automatic sample_t clamp_q16(input longint x);
    if (x > S_MAX) return Q_MAX;
    if (x < S_MIN) return Q_MIN;
    return sample_t'(x);
  endfunction

  // Build a random set: mostly values drifting around a per-channel center with noise
  // scaled to the limit, plus probes right at the median +/- limit, repeats, extremes and random codes.
  function automatic set_t random_set();
    set_t        s;
    int unsigned r;
    longint      amp;
    longint      off;
    for (int c = 0; c < NUM_CHAN; c++) begin
      if ($urandom_range(0, 99) < 3)
        drift_center[c] = longint'($signed($urandom)) >>> $urandom_range(0, 20);
      r = $urandom_range(0, 99);
      if (r < 6) begin
        s[c] = sample_t'($urandom);
      end else if (r < 12) begin
        case ($urandom_range(0, 3))
          0:       s[c] = Q_MIN;
          1:       s[c] = Q_MAX;
          2:       s[c] = '0;
          default: s[c] = '1;
        endcase
      end else if (r < 18 && win_count >= WIN) begin
        s[c] = win_hist[c][WIN - 1];
      end else if (r < 42 && win_count >= WIN) begin
        off = longint'(chan_limit(c)) + longint'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1)) off = -off;
        s[c] = clamp_q16(longint'(window_median(c)) + off);
      end else begin
        amp = 2 * longint'(chan_limit(c)) + 64;
        if (amp > S_MAX) amp = S_MAX;
        s[c] = clamp_q16(drift_center[c] + longint'($urandom_range(0, 32'(2 * amp))) - amp);
      end
    end
    return s;
  endfunction

  task automatic drive_payload(input set_t s);
    in_bus.accel_x  <= s[0];
    in_bus.accel_y  <= s[1];
    in_bus.accel_z  <= s[2];
    in_bus.gyro_x   <= s[3];
    in_bus.gyro_y   <= s[4];
    in_bus.gyro_z   <= s[5];
    in_bus.orient_x <= s[6];
    in_bus.orient_y <= s[7];
    in_bus.orient_z <= s[8];
    in_bus.orient_w <= s[9];
  endtask

  // Offer one set and hold it until the transfer; queue either the typed result or the
  // predicted one. The predictor always advances so later rows see the right windows.
  task automatic offer_set(input set_t s, input bit typed, input alarm_res_t typed_res);
    alarm_res_t res;
    in_bus.valid <= 1'b1;
    drive_payload(s);
    do @(posedge clk); while (!in_bus.ready);
    res = predict_alarms(s);
    pending_alarms.insert(pending_alarms.size(), typed ? typed_res : res);
  endtask

  // Sender pacing: bursts of random length, random gaps with junk on the idle bus.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
      return;
    end
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      drive_payload(random_set());
      repeat (gap) @(posedge clk);
    end
    burst_left = $urandom_range(1, 24);
  endtask

  task automatic check_limit(input reg_idx_t idx);
    logic [APB_DATA_W-1:0] want;
    want = (idx == REG_ACCEL_LIMIT) ? APB_DATA_W'(acc_lim_q) : APB_DATA_W'(oth_lim_q);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      report_mismatch($sformatf("read %s: got %h want %h", idx.name(), prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write a limit; bit 31 of the data is dropped by the block, so drop it here too.
  task automatic write_limit(input reg_idx_t idx, input logic [APB_DATA_W-1:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_ACCEL_LIMIT) acc_lim_q = limit_t'(val);
    else                        oth_lim_q = limit_t'(val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    check_limit(idx);
  endtask

  // Wait for every queued result, then let the two pipeline stages settle.
  task automatic wait_drained();
    while (pending_alarms.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result side: check every transfer against the oldest expectation.
  always @(posedge clk) begin
    alarm_res_t want_res;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_alarms.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: mask=%h full=%b",
                                  out_bus.alarm_mask, out_bus.window_full));
      end else begin
        want_res = pending_alarms.pop_front();
        if (out_bus.alarm_mask !== want_res.mask)
          report_mismatch($sformatf("alarm_mask: got %h want %h",
                                    out_bus.alarm_mask, want_res.mask));
        if (out_bus.window_full !== want_res.full)
          report_mismatch($sformatf("window_full: got %b want %b",
                                    out_bus.window_full, want_res.full));
      end
    end
  end

  // Receiver: stretches of always-ready, random, periodic and mostly-stalled ready;
  // once, on request, hold ready low long enough to back the block up to its input.
  initial begin
    int unsigned mode;
    int unsigned span;
    out_bus.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        for (int k = 0; k < HOLD_OFF_LEN; k++) begin
          out_bus.ready <= 1'b0;
          @(posedge clk);
        end
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(4, 60);
        for (int k = 0; k < span; k++) begin
          case (mode)
            0:       out_bus.ready <= 1'b1;
            1:       out_bus.ready <= ($urandom_range(0, 9) < 7);
            2:       out_bus.ready <= (k % 3 == 0);
            default: out_bus.ready <= ($urandom_range(0, 9) < 2);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Watchdog: count cycles and end a hung run.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("** imu_median_outlier_check: FAILED **");
    $finish;
  end

  // Main sequence: reset, directed rows at the reset limits, then random phases with
  // a limit setting each, extremes among them.
  initial begin
    set_t        s;
    stim_row_t   row;
    alarm_res_t  typed_res;
    int unsigned acc_w;
    int unsigned oth_w;

    foreach (drift_center[c]) drift_center[c] = 0;
    rst_n        <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    in_bus.valid <= 1'b0;
    for (int c = 0; c < NUM_CHAN; c++) s[c] = '0;
    drive_payload(s);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Confirm the reset limits before any traffic.
    check_limit(REG_ACCEL_LIMIT);
    check_limit(REG_OTHER_LIMIT);

    // Walk the directed table.
    for (int r = 0; r < $size(DIRECTED_ROWS); r++) begin
      row = DIRECTED_ROWS[r];
      for (int c = 0; c < NUM_CHAN; c++)
        s[c] = sample_t'(((c < NUM_ACCEL) ? row.acc : row.oth) + row.step * c);
      typed_res.mask = row.mask;
      typed_res.full = row.full;
      offer_set(s, row.chk, typed_res);
      pace_sender();
    end

    // Random phases; each starts from an idle block with fresh limits.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      in_bus.valid <= 1'b0;
      wait_drained();
      case (ph)
        0: begin
          acc_w = $urandom_range(1, 32'h0010_0000);
          oth_w = $urandom_range(1, 32'h0004_0000);
        end
        1: begin
          acc_w = 32'h0000_0000;
          oth_w = 32'h0000_0000;
        end
        2: begin
          acc_w = 32'h7FFF_FFFF;
          oth_w = 32'h7FFF_FFFF;
        end
        3: begin
          // Top bit set on both: drop it, leaving the maximum and zero.
          acc_w = 32'hFFFF_FFFF;
          oth_w = 32'h8000_0000;
        end
        default: begin
          acc_w = $urandom;
          oth_w = $urandom_range(0, 32'h0000_4000);
        end
      endcase
      write_limit(REG_ACCEL_LIMIT, acc_w);
      write_limit(REG_OTHER_LIMIT, oth_w);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 0 && n == 60) hold_off_req = 1'b1;
        offer_set(random_set(), 1'b0, typed_res);
        pace_sender();
      end
    end

    in_bus.valid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (pending_alarms.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_alarms.size()));

    if (err_cnt == 0) begin
      $display("** imu_median_outlier_check: PASSED **");
    end else begin
      $display("** imu_median_outlier_check: FAILED **");
    end
    $finish;
  end

endmodule
